[rtl/core/tsed_pkg.sv]
// shared types and constants of the threshold spike event detector
// no dependencies; imported by every module of the block except tsed_ram

package tsed_pkg;

   localparam int CHANNELS = 64;
   localparam int CH_W     = 6;
   localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 64;
   localparam logic [CSR_AW-1:0] CSR_ADDR_REPORT_MASK = CSR_AW'(0);
   localparam logic [CSR_DW-1:0] REPORT_MASK_RESET    = '1;

   localparam logic [15:0] WIDTH_MAX = 16'hFFFF;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic [31:0]        sample_time;
      logic signed [15:0] sample_value;
      logic signed [15:0] upper_threshold;
      logic signed [15:0] lower_threshold;
   } sample_item_type;

   typedef struct packed {
      logic               downward;
      logic [31:0]        start_time;
      logic [31:0]        peak_time;
      logic signed [15:0] peak_value;
   } spike_rec_type;

   localparam int REC_W = $bits(spike_rec_type);

   typedef struct packed {
      logic [CH_W-1:0]    event_channel;
      logic [31:0]        peak_time;
      logic [15:0]        spike_width;
      logic signed [15:0] peak_height;
      logic signed [15:0] event_threshold;
   } spike_event_type;

   typedef struct packed {
      logic write;
      logic open_next;
      logic emit;
   } update_ctl_type;

endpackage

[rtl/core/tsed_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies

module tsed_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tsed_csr.sv]
// apb register block holding the per-channel report mask
// depends on tsed_pkg

module tsed_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tsed_pkg::CSR_AW-1:0]  paddr,
   input  logic [tsed_pkg::CSR_DW-1:0]  pwdata,
   output logic [tsed_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready,
   output logic [tsed_pkg::CSR_DW-1:0]  report_mask
);
   import tsed_pkg::*;

   logic [CSR_DW-1:0] mask_ff;
   logic [CSR_DW-1:0] mask_in;
   logic              wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && pready && (paddr == CSR_ADDR_REPORT_MASK);

   always_comb begin
      mask_in = mask_ff;
      if (wr_hit) begin
         mask_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= REPORT_MASK_RESET;
      end else begin
         mask_ff <= mask_in;
      end
   end

   assign prdata      = (paddr == CSR_ADDR_REPORT_MASK) ? mask_ff : '0;
   assign report_mask = mask_ff;

endmodule

[rtl/core/tsed_update.sv]
// read-modify-write datapath: open, track peak, close and build the event
// depends on tsed_pkg

module tsed_update (
   input  tsed_pkg::sample_item_type item,
   input  logic                      rec_open,
   input  tsed_pkg::spike_rec_type   rec_cur,
   input  logic                      mask_bit,
   output tsed_pkg::update_ctl_type  ctl,
   output tsed_pkg::spike_rec_type   rec_next,
   output tsed_pkg::spike_event_type evt
);
   import tsed_pkg::*;

   logic               in_range;
   logic signed [18:0] y_x5;
   logic signed [18:0] up_x4;
   logic signed [18:0] dn_x4;
   logic               closing;
   logic signed [15:0] thr;
   logic [31:0]        dur;

   assign in_range = ({1'b0, item.channel} < (CH_W+1)'(CHANNELS));

   // exact 0.8 test: 5*y against 4*thr
   assign y_x5  = (19'(item.sample_value) <<< 2) + 19'(item.sample_value);
   assign up_x4 = 19'(item.upper_threshold) <<< 2;
   assign dn_x4 = 19'(item.lower_threshold) <<< 2;

   always_comb begin
      rec_next = rec_cur;
      closing  = 1'b0;
      thr      = item.upper_threshold;
      ctl      = '{write: 1'b0, open_next: rec_open, emit: 1'b0};
      if (in_range) begin
         ctl.write = 1'b1;
         if (rec_open) begin
            if (rec_cur.downward) begin
               if (item.sample_value < rec_cur.peak_value) begin
                  rec_next.peak_value = item.sample_value;
                  rec_next.peak_time  = item.sample_time;
               end else if (y_x5 > dn_x4) begin
                  closing = 1'b1;
                  thr     = item.lower_threshold;
               end
            end else begin
               if (item.sample_value > rec_cur.peak_value) begin
                  rec_next.peak_value = item.sample_value;
                  rec_next.peak_time  = item.sample_time;
               end else if (y_x5 < up_x4) begin
                  closing = 1'b1;
                  thr     = item.upper_threshold;
               end
            end
            ctl.open_next = !closing;
            ctl.emit      = closing && mask_bit;
         end else if ((item.sample_value > item.upper_threshold) ||
                      (item.sample_value < item.lower_threshold)) begin
            // upward test wins when both thresholds are crossed
            ctl.open_next       = 1'b1;
            rec_next.downward   = !(item.sample_value > item.upper_threshold);
            rec_next.start_time = item.sample_time;
            rec_next.peak_time  = item.sample_time;
            rec_next.peak_value = item.sample_value;
         end
      end
   end

   assign dur = item.sample_time - rec_cur.start_time;

   always_comb begin
      evt.event_channel   = item.channel;
      evt.peak_time       = rec_cur.peak_time;
      evt.spike_width     = (|dur[31:16]) ? WIDTH_MAX : dur[15:0];
      evt.peak_height     = rec_cur.peak_value;
      evt.event_threshold = thr;
   end

endmodule

[rtl/core/threshold_spike_event_detector_top.sv]
// an accepted item is registered in s1, and its event, if any, in the output register
// throughput: one item per cycle while no event is stalled; the channel record ram is
// read in the accept cycle and written back as the item leaves s1, a one-deep forward
// covers the same channel; the whole pipeline holds only while a waiting event is stalled
// reset: synchronous; clears the spike-open flags of all channels and the
// pipeline valids, and sets the report mask to all ones; no clearing pass

module threshold_spike_event_detector_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tsed_pkg::CH_W-1:0]     req_channel,
   input  logic [31:0]                   req_sample_time,
   input  logic signed [15:0]            req_sample_value,
   input  logic signed [15:0]            req_upper_threshold,
   input  logic signed [15:0]            req_lower_threshold,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tsed_pkg::CH_W-1:0]     rsp_event_channel,
   output logic [31:0]                   rsp_peak_time,
   output logic [15:0]                   rsp_spike_width,
   output logic signed [15:0]            rsp_peak_height,
   output logic signed [15:0]            rsp_event_threshold,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tsed_pkg::CSR_AW-1:0]   paddr,
   input  logic [tsed_pkg::CSR_DW-1:0]   pwdata,
   output logic [tsed_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import tsed_pkg::*;

   logic            advance;
   logic            accept;
   logic [CSR_DW-1:0] report_mask;

   logic            s1_valid_ff, s1_valid_in;
   sample_item_type s1_item_ff, s1_item_in;
   logic [CH_AW-1:0] s1_addr;

   logic            fwd_valid_ff, fwd_valid_in;
   logic [CH_AW-1:0] fwd_addr_ff, fwd_addr_in;
   spike_rec_type   fwd_rec_ff, fwd_rec_in;

   logic [CHANNELS-1:0] open_ff, open_in;

   logic            out_valid_ff, out_valid_in;
   spike_event_type out_evt_ff, out_evt_in;

   logic [REC_W-1:0] ram_rd_data;
   spike_rec_type    rec_cur;
   spike_rec_type    rec_next;
   update_ctl_type   ctl;
   spike_event_type  evt;
   logic             ram_we;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   assign s1_addr = s1_item_ff.channel[CH_AW-1:0];
   assign ram_we  = s1_valid_ff && advance && ctl.write;

   tsed_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .report_mask (report_mask)
   );

   tsed_ram #(
      .WIDTH (REC_W),
      .DEPTH (CHANNELS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr),
      .wr_data (rec_next),
      .rd_en   (accept),
      .rd_addr (req_channel[CH_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // the write that landed at the same edge as this item's read is not in rd_data
   assign rec_cur = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ?
                    fwd_rec_ff : spike_rec_type'(ram_rd_data);

   tsed_update u_update (
      .item     (s1_item_ff),
      .rec_open (open_ff[s1_addr]),
      .rec_cur  (rec_cur),
      .mask_bit (report_mask[s1_item_ff.channel]),
      .ctl      (ctl),
      .rec_next (rec_next),
      .evt      (evt)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_rec_in   = fwd_rec_ff;
      open_in      = open_ff;
      out_valid_in = out_valid_ff;
      out_evt_in   = out_evt_ff;
      if (advance) begin
         s1_valid_in  = accept;
         if (accept) begin
            s1_item_in = '{channel:         req_channel,
                           sample_time:     req_sample_time,
                           sample_value:    req_sample_value,
                           upper_threshold: req_upper_threshold,
                           lower_threshold: req_lower_threshold};
         end
         fwd_valid_in = ram_we;
         fwd_addr_in  = s1_addr;
         fwd_rec_in   = rec_next;
         if (ram_we) begin
            open_in[s1_addr] = ctl.open_next;
         end
         out_valid_in = s1_valid_ff && ctl.emit;
         if (s1_valid_ff && ctl.emit) begin
            out_evt_in = evt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         open_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         open_ff      <= open_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_rec_ff  <= fwd_rec_in;
      out_evt_ff  <= out_evt_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_event_channel   = out_evt_ff.event_channel;
   assign rsp_peak_time       = out_evt_ff.peak_time;
   assign rsp_spike_width     = out_evt_ff.spike_width;
   assign rsp_peak_height     = out_evt_ff.peak_height;
   assign rsp_event_threshold = out_evt_ff.event_threshold;

endmodule

[rtl/core/tsed_checker.sv]
// port-level checks of the spike event detector, bound to the top level
// depends on tsed_pkg and threshold_spike_event_detector_top

module tsed_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [tsed_pkg::CH_W-1:0]     rsp_event_channel,
   input logic [31:0]                   rsp_peak_time,
   input logic [15:0]                   rsp_spike_width,
   input logic signed [15:0]            rsp_peak_height,
   input logic signed [15:0]            rsp_event_threshold,
   input logic                          psel,
   input logic                          penable,
   input logic                          pready
);
   import tsed_pkg::*;

   // no event survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("event valid after reset");

   // a stalled event holds its payload
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_channel) &&
         $stable(rsp_peak_time) && $stable(rsp_spike_width) &&
         $stable(rsp_peak_height) && $stable(rsp_event_threshold))
      else $error("stalled event changed");

   // the pipeline holds exactly while a waiting event is stalled
   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not match output backpressure");

   // register port never waits
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      psel && penable |-> pready)
      else $error("register access not ready");

endmodule

bind threshold_spike_event_detector_top tsed_checker u_tsed_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_event_channel   (rsp_event_channel),
   .rsp_peak_time       (rsp_peak_time),
   .rsp_spike_width     (rsp_spike_width),
   .rsp_peak_height     (rsp_peak_height),
   .rsp_event_threshold (rsp_event_threshold),
   .psel                (psel),
   .penable             (penable),
   .pready              (pready)
);
